### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the IR frame decoder.
// No dependencies; take it in by `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define NECIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define NECIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must hold at every edge while reset is asserted.
`define NECIR_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
	lbl: assert property (@(posedge clk) !(rst_n) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/necir_pkg.sv
// Types and constants of the NEC IR frame decoder.
// No dependencies; used by every module of the decoder.
package necir_pkg;

	localparam int unsigned TICK_W   = 24;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned CFG_IX_W = 8;

	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CFG_IX_W-1:0] cfg_ix_t;

	// register indexes of the configuration port
	localparam cfg_ix_t CFG_START_MIN = 8'd0;
	localparam cfg_ix_t CFG_START_MAX = 8'd1;
	localparam cfg_ix_t CFG_ONE_MIN   = 8'd2;
	localparam cfg_ix_t CFG_ONE_MAX   = 8'd3;

	localparam tick_t START_MIN_RST = 24'd10000;
	localparam tick_t START_MAX_RST = 24'd14000;
	localparam tick_t ONE_MIN_RST   = 24'd2000;
	localparam tick_t ONE_MAX_RST   = 24'd2300;

	// interval positions within a frame (0 is the leader)
	localparam cnt_t LEADER_IDX = 6'd0;
	localparam cnt_t ADDR_FIRST = 6'd1;
	localparam cnt_t ADDR_LAST  = 6'd8;
	localparam cnt_t CMD_FIRST  = 6'd17;
	localparam cnt_t CMD_LAST   = 6'd24;
	localparam cnt_t LAST_IDX   = 6'd32;

	typedef struct packed {
		tick_t start_min;
		tick_t start_max;
		tick_t one_min;
		tick_t one_max;
	} cfg_t;

	typedef struct packed {
		logic leader_hit;
		logic one_hit;
	} win_t;

	typedef struct packed {
		logic  emit;
		byte_t address;
		byte_t command;
	} frame_out_t;

endpackage

### rtl/core/necir_classify.sv
// Window comparators: classifies one interval against the leader and one-bit windows.
// Depends on necir_pkg.
module necir_classify (
	input  necir_pkg::tick_t ticks,
	input  necir_pkg::cfg_t  cfg,
	output necir_pkg::win_t  win
);

	assign win.leader_hit = (ticks >= cfg.start_min) && (ticks <= cfg.start_max);
	assign win.one_hit    = (ticks >= cfg.one_min) && (ticks <= cfg.one_max);

endmodule

### rtl/core/necir_frame.sv
// Frame sequencer: arming, interval count, leader flag and byte shift registers.
// Depends on necir_pkg.
module necir_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  necir_pkg::win_t       win,
	output necir_pkg::frame_out_t pend
);

	logic             armed_q;
	necir_pkg::cnt_t  count_q;
	logic             leader_q;
	necir_pkg::byte_t address_q;
	necir_pkg::byte_t command_q;

	logic in_addr;
	logic in_cmd;
	logic last;

	assign in_addr = (count_q >= necir_pkg::ADDR_FIRST) && (count_q <= necir_pkg::ADDR_LAST);
	assign in_cmd  = (count_q >= necir_pkg::CMD_FIRST) && (count_q <= necir_pkg::CMD_LAST);
	assign last    = armed_q && (count_q == necir_pkg::LAST_IDX);

	// the final interval touches neither byte, so the stored state is the result
	assign pend.emit    = last && leader_q;
	assign pend.address = address_q;
	assign pend.command = command_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			count_q   <= '0;
			leader_q  <= 1'b0;
			address_q <= '0;
			command_q <= '0;
		end else if (step) begin
			if (!armed_q || last) begin
				// arm on a fresh edge; drop back to waiting after the last interval
				armed_q   <= !armed_q;
				count_q   <= '0;
				leader_q  <= 1'b0;
				address_q <= '0;
				command_q <= '0;
			end else begin
				count_q <= count_q + necir_pkg::cnt_t'(1);
				if (count_q == necir_pkg::LEADER_IDX) begin
					leader_q <= win.leader_hit;
				end
				// LSB first: shift in from the top
				if (in_addr) begin
					address_q <= {win.one_hit, address_q[necir_pkg::BYTE_W-1:1]};
				end
				if (in_cmd) begin
					command_q <= {win.one_hit, command_q[necir_pkg::BYTE_W-1:1]};
				end
			end
		end
	end

endmodule

### rtl/core/nec_ir_frame_decoder_core.sv
// Top level of the NEC IR frame decoder: input register, window compare,
// frame sequencer, result register and configuration registers.
// Depends on necir_pkg, necir_classify and necir_frame.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | to core   | in_valid / in_ready    | interval_ticks[23:0]
//  out     | from core | out_valid / out_ready  | address_byte[7:0], command_byte[7:0]
//  cfg     | to core   | cfg_valid / cfg_ready  | cfg_index[7:0], cfg_data[23:0]
//
// One edge transaction per cycle unless the staged edge is held back; an edge
// is classified and folded into the frame state as it leaves the input register,
// and a frame result is loaded into the result register in the same cycle, so
// out_valid rises once the last edge leaves the input register. The rate is set
// by the combinational window compare and frame update between the two registers.
// Reset clears the frame state and loads the default window registers.
// A stalled result register holds back only the last edge of a frame with a good
// leader, and later edges wait behind it. cfg_ready is always high.
module nec_ir_frame_decoder_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  necir_pkg::tick_t         interval_ticks,
	output logic                     out_valid,
	input  logic                     out_ready,
	output necir_pkg::byte_t         address_byte,
	output necir_pkg::byte_t         command_byte,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  necir_pkg::cfg_ix_t       cfg_index,
	input  necir_pkg::tick_t         cfg_data
);

	// window registers
	necir_pkg::cfg_t cfg_q;

	// input register stage
	logic             valid_s1;
	necir_pkg::tick_t ticks_s1;

	necir_pkg::win_t       win;
	necir_pkg::frame_out_t pend;

	// result register
	logic             out_valid_q;
	necir_pkg::byte_t address_q;
	necir_pkg::byte_t command_q;

	logic fire_s1;

	// Advance the staged edge unless it completes a good frame while the
	// result register is still full and not being taken.
	assign fire_s1  = valid_s1 && (!pend.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min <= necir_pkg::START_MIN_RST;
			cfg_q.start_max <= necir_pkg::START_MAX_RST;
			cfg_q.one_min   <= necir_pkg::ONE_MIN_RST;
			cfg_q.one_max   <= necir_pkg::ONE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				necir_pkg::CFG_START_MIN: cfg_q.start_min <= cfg_data;
				necir_pkg::CFG_START_MAX: cfg_q.start_max <= cfg_data;
				necir_pkg::CFG_ONE_MIN:   cfg_q.one_min   <= cfg_data;
				necir_pkg::CFG_ONE_MAX:   cfg_q.one_max   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: take a new edge whenever the stage is empty or advancing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ticks_s1 <= interval_ticks;
		end
	end

	necir_classify u_classify (
		.ticks (ticks_s1),
		.cfg   (cfg_q),
		.win   (win)
	);

	necir_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire_s1),
		.win    (win),
		.pend   (pend)
	);

	// Result register: load on a good frame end, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && pend.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && pend.emit) begin
			address_q <= pend.address;
			command_q <= pend.command;
		end
	end

	assign out_valid    = out_valid_q;
	assign address_byte = address_q;
	assign command_byte = command_q;

endmodule

### rtl/core/necir_checker.sv
// Port-level checks of the NEC IR frame decoder, bound to the top level.
// Depends on necir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module necir_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input necir_pkg::byte_t   address_byte,
	input necir_pkg::byte_t   command_byte
);

	// input backpressure only comes from a full, stalled result
	`NECIR_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "in_ready low without stalled output")

	// a new result needs in_ready high in the cycle before
	`NECIR_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid), $past(in_ready), "result appeared without an edge advancing")

	// a stalled result holds its bytes
	`NECIR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(address_byte) && $stable(command_byte), "stalled result changed")

	// no result while reset is applied
	`NECIR_ASSERT_RST(a_rst_quiet, clk, arst_n, out_valid !== 1'b1, "out_valid high during reset")

endmodule

bind nec_ir_frame_decoder_core necir_checker u_necir_checker (.*);

### dv/nec_ir_frame_decoder_checker.sv
// Checker of the NEC IR frame decoder: watches the edge, result and register channels,
// predicts each decoded frame and compares it with what the core returns.
// Depends on necir_pkg.
module nec_ir_frame_decoder_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  necir_pkg::tick_t   interval_ticks,
	input  logic               out_valid,
	input  logic               out_ready,
	input  necir_pkg::byte_t   address_byte,
	input  necir_pkg::byte_t   command_byte,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  necir_pkg::cfg_ix_t cfg_index,
	input  necir_pkg::tick_t   cfg_data,
	output int                 fail_count,
	output int                 pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import necir_pkg::*;

	typedef struct packed {
		byte_t address;
		byte_t command;
	} frame_t;

	frame_t expected_frames[$];
	cfg_t   windows;
	logic   armed;
	cnt_t   edge_count;
	logic   leader_ok;
	byte_t  addr_shift;
	byte_t  cmd_shift;
	int     errors = 0;

	assign fail_count = errors;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic in_window(input tick_t v, input tick_t lo, input tick_t hi);
		return v >= lo && v <= hi;
	endfunction

	task automatic clear_frame();
		armed      = 1'b0;
		edge_count = LEADER_IDX;
		leader_ok  = 1'b0;
		addr_shift = '0;
		cmd_shift  = '0;
	endtask

	// Fold one falling edge into the frame state; queue a frame on its last interval if the leader was good.
	task automatic decode_frame_edge(input tick_t ticks);
		logic  one;
		if (!armed) begin
			clear_frame();
			armed = 1'b1;
		end else begin
			if (edge_count == LEADER_IDX) begin
				leader_ok = in_window(ticks, windows.start_min, windows.start_max);
			end else begin
				one = in_window(ticks, windows.one_min, windows.one_max);
				if (edge_count >= ADDR_FIRST && edge_count <= ADDR_LAST)
					addr_shift[edge_count - ADDR_FIRST] = one;
				else if (edge_count >= CMD_FIRST && edge_count <= CMD_LAST)
					cmd_shift[edge_count - CMD_FIRST] = one;
			end
			if (edge_count == LAST_IDX) begin
				if (leader_ok)
					expected_frames.push_back('{address: addr_shift, command: cmd_shift});
				clear_frame();
			end else begin
				edge_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			windows = '{start_min: START_MIN_RST, start_max: START_MAX_RST,
				one_min: ONE_MIN_RST, one_max: ONE_MAX_RST};
			clear_frame();
			expected_frames.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch($sformatf("frame %02h/%02h with none expected",
						address_byte, command_byte));
				end else begin
					want = expected_frames.pop_front();
					if (address_byte !== want.address)
						report_mismatch($sformatf("address_byte %02h, want %02h",
							address_byte, want.address));
					if (command_byte !== want.command)
						report_mismatch($sformatf("command_byte %02h, want %02h",
							command_byte, want.command));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_MIN: windows.start_min = cfg_data;
					CFG_START_MAX: windows.start_max = cfg_data;
					CFG_ONE_MIN:   windows.one_min   = cfg_data;
					CFG_ONE_MAX:   windows.one_max   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				decode_frame_edge(interval_ticks);
			pending_count <= expected_frames.size();
		end
	end

endmodule

### dv/nec_ir_frame_decoder_core_tb.sv
// Testbench top of the NEC IR frame decoder: clock, reset, edge and register stimulus,
// random result back-pressure and the verdict.
// Depends on necir_pkg, nec_ir_frame_decoder_core and nec_ir_frame_decoder_checker.
module nec_ir_frame_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import necir_pkg::*;

	localparam int    ITEM_TARGET = 1450;
	localparam int    PHASES      = 8;
	localparam int    CYCLE_LIMIT = 200000;
	localparam int    IDLE_PCT    = 12;
	// arming edge plus leader plus 32 bit intervals
	localparam int    FRAME_EDGES = LAST_IDX + 2;
	localparam tick_t TICK_MAX    = {TICK_W{1'b1}};

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	tick_t   interval_ticks;
	logic    out_valid;
	logic    out_ready;
	byte_t   address_byte;
	byte_t   command_byte;
	logic    cfg_valid;
	logic    cfg_ready;
	cfg_ix_t cfg_index;
	tick_t   cfg_data;

	int fail_count;
	int pending_count;
	int cycles = 0;

	// Stimulus copy of the windows, used only to aim intervals at or around them.
	tick_t s_min, s_max, o_min, o_max;
	int    frame_pos;
	int    sent;
	logic  quiet;

	nec_ir_frame_decoder_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.interval_ticks (interval_ticks),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.address_byte   (address_byte),
		.command_byte   (command_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	nec_ir_frame_decoder_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.interval_ticks (interval_ticks),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.address_byte   (address_byte),
		.command_byte   (command_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop: a hung handshake or a lost frame ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result back-pressure: short random stalls, plus now and then a long one so that
	// the result register stays full while the next frame comes in behind it.
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if ($urandom_range(299) == 0) begin
			stall_left <= $urandom_range(80, 20);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Pick an interval inside [lo, hi], favoring both boundaries; any value if the window is empty.
	function automatic tick_t pick_in(input tick_t lo, input tick_t hi);
		if (lo > hi)
			return tick_t'($urandom);
		case ($urandom_range(3))
			0:       return lo;
			1:       return hi;
			default: return tick_t'($urandom_range(hi, lo));
		endcase
	endfunction

	// Pick an interval outside [lo, hi], often right next to a boundary.
	function automatic tick_t pick_out(input tick_t lo, input tick_t hi);
		logic below_ok;
		logic above_ok;
		below_ok = (lo != 0);
		above_ok = (hi != TICK_MAX);
		if (lo > hi || (!below_ok && !above_ok))
			return tick_t'($urandom);
		if (!above_ok || (below_ok && $urandom_range(1) == 1)) begin
			if ($urandom_range(1) == 1)
				return tick_t'(lo - 1);
			return tick_t'($urandom_range(lo - 1, 0));
		end
		if ($urandom_range(1) == 1)
			return tick_t'(hi + 1);
		return tick_t'($urandom_range(TICK_MAX, hi + 1));
	endfunction

	// Present one falling edge and hold it until the transaction completes.
	task automatic send_edge(input tick_t ticks);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		interval_ticks <= ticks;
		do @(posedge clk); while (!in_ready);
		frame_pos = (frame_pos + 1) % FRAME_EDGES;
		sent++;
	endtask

	// Arming edge, leader, then 32 bit intervals LSB first.
	task automatic send_frame(input tick_t leader, input logic [31:0] word);
		send_edge(tick_t'($urandom));
		send_edge(leader);
		for (int i = 0; i < 32; i++)
			send_edge(word[i] ? pick_in(o_min, o_max) : pick_out(o_min, o_max));
	endtask

	// Fill the current frame with junk up to the next arming edge.
	task automatic pad_frame();
		while (frame_pos != 0)
			send_edge(tick_t'($urandom));
	endtask

	task automatic write_reg(input cfg_ix_t ix, input tick_t data);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ix)
			CFG_START_MIN: s_min = data;
			CFG_START_MAX: s_max = data;
			CFG_ONE_MIN:   o_min = data;
			CFG_ONE_MAX:   o_max = data;
			default: ;
		endcase
	endtask

	task automatic set_windows(input tick_t smin, input tick_t smax,
		input tick_t omin, input tick_t omax);
		write_reg(CFG_START_MIN, smin);
		write_reg(CFG_START_MAX, smax);
		write_reg(CFG_ONE_MIN, omin);
		write_reg(CFG_ONE_MAX, omax);
	endtask

	// Write to an index past the last register: must change nothing.
	task automatic write_unknown();
		write_reg(cfg_ix_t'($urandom_range({CFG_IX_W{1'b1}}, CFG_ONE_MAX + 1)),
			tick_t'($urandom));
	endtask

	// Drop valid, wait until every expected frame is back, then let the pipeline
	// settle (a frame result is registered once its last edge leaves the input register).
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic configure(input int phase);
		tick_t lo;
		tick_t one_lo;
		case (phase)
			// widest leader window, one decodes only from a zero interval
			1: set_windows('0, TICK_MAX, '0, '0);
			// everything pinned to the top of the range
			2: set_windows(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
			// empty leader window: no frame may come out
			3: set_windows(24'd5000, 24'd4000, 24'd100, 24'd200);
			// empty one window: every bit decodes as zero
			4: set_windows(24'd9000, 24'd9500, 24'd3000, 24'd2000);
			5, 6: begin
				write_unknown();
				lo     = tick_t'($urandom);
				one_lo = tick_t'($urandom_range(TICK_MAX >> 4));
				set_windows(lo, (lo > TICK_MAX - 24'd4000) ? TICK_MAX :
					tick_t'(lo + $urandom_range(4000)),
					one_lo, tick_t'(one_lo + $urandom_range(600)));
				write_unknown();
			end
			default: begin
				set_windows(START_MIN_RST, START_MAX_RST, ONE_MIN_RST, ONE_MAX_RST);
				write_unknown();
			end
		endcase
	endtask

	// One chunk of random stimulus, always ending on a frame boundary.
	task automatic random_chunk();
		int          pick;
		int          n;
		byte_t       addr;
		byte_t       cmd;
		byte_t       addr_inv;
		byte_t       cmd_inv;
		pick     = $urandom_range(99);
		addr     = byte_t'($urandom);
		cmd      = byte_t'($urandom);
		// mostly proper inverses, sometimes garbage that must be ignored
		addr_inv = ($urandom_range(3) == 0) ? byte_t'($urandom) : ~addr;
		cmd_inv  = ($urandom_range(3) == 0) ? byte_t'($urandom) : ~cmd;
		if (pick < 70) begin
			send_frame(pick_in(s_min, s_max), {cmd_inv, cmd, addr_inv, addr});
		end else if (pick < 82) begin
			send_frame(pick_out(s_min, s_max), {cmd_inv, cmd, addr_inv, addr});
		end else begin
			// noise: full-range intervals, then junk to the end of the broken frame
			n = $urandom_range(40, 1);
			repeat (n) begin
				case ($urandom_range(3))
					0:       send_edge('0);
					1:       send_edge(TICK_MAX);
					default: send_edge(tick_t'($urandom));
				endcase
			end
			pad_frame();
		end
	endtask

	initial begin
		tick_t dir_bits[32];
		in_valid       = 1'b0;
		interval_ticks = '0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_START_MIN;
		cfg_data       = '0;
		quiet          = 1'b0;
		arst_n         = 1'b0;
		frame_pos      = 0;
		sent           = 0;
		s_min          = START_MIN_RST;
		s_max          = START_MAX_RST;
		o_min          = ONE_MIN_RST;
		o_max          = ONE_MAX_RST;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frame on the reset windows: leader on its lower bound, bits on both
		// one-window bounds, just outside them, and at both ends of the tick range.
		// Address comes out as C3, command as CA.
		dir_bits = '{
			ONE_MIN_RST, ONE_MAX_RST, tick_t'(ONE_MIN_RST - 1), tick_t'(ONE_MAX_RST + 1),
			'0, TICK_MAX, ONE_MIN_RST, ONE_MAX_RST,
			'0, '0, TICK_MAX, TICK_MAX, ONE_MIN_RST, ONE_MAX_RST, '0, '0,
			tick_t'(ONE_MAX_RST + 1), ONE_MIN_RST, '0, ONE_MAX_RST,
			TICK_MAX, tick_t'(ONE_MIN_RST - 1), ONE_MIN_RST, ONE_MAX_RST,
			ONE_MIN_RST, ONE_MAX_RST, '0, TICK_MAX, '0, ONE_MIN_RST, TICK_MAX, '0
		};
		send_edge(TICK_MAX);
		send_edge(START_MIN_RST);
		foreach (dir_bits[i])
			send_edge(dir_bits[i]);

		// Random phases, each on its own window setting; registers change only
		// once the core has gone idle.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				drain();
				configure(phase);
			end
			// hold the receiver ready for one whole phase
			quiet <= (phase == 1);
			while (sent < (phase + 1) * ITEM_TARGET / PHASES)
				random_chunk();
		end

		drain();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
